// ----- hdl/cpsf_pkg.sv -----
// Shared types and codes for the constant-pattern string filter.
// No dependencies; imported by cpsf_core, constant_pattern_string_filter_top and both tb files.
package cpsf_pkg;

  typedef enum logic [2:0] {
    MODE_ALL    = 3'd0,
    MODE_EQUALS = 3'd1,
    MODE_STARTS = 3'd2,
    MODE_ENDS   = 3'd3,
    MODE_CONTAINS = 3'd4
  } mode_e;

  // Register index = paddr[4:3] (64-bit registers at 8-byte stride)
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_LENGTH = 2'd1,
    REG_LOW    = 2'd2,
    REG_HIGH   = 2'd3
  } reg_e;

  localparam int unsigned NeedleBytesMax = 16;

  typedef struct packed {
    logic [2:0]   match_mode;
    logic [4:0]   needle_length;
    logic [127:0] needle;        // byte 0 in bits 7..0
  } cfg_t;

  typedef struct packed {
    logic       last_byte;
    logic       is_empty;
    logic [7:0] data_byte;
  } item_t;

endpackage

// ----- hdl/cpsf_core.sv -----
// Per-string match state and match decision for one item per cycle while step_i is high.
// Depends on cpsf_pkg (cfg_t, item_t, mode_e).
module cpsf_core import cpsf_pkg::*; #(
  parameter int unsigned NEEDLE_MAX = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  step_i,
  input  item_t item_i,
  output logic  match_o
);

  localparam int unsigned LW = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned CW = $clog2(NEEDLE_MAX + 2);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    win_q [NEEDLE_MAX];
  logic [7:0]    cw    [NEEDLE_MAX];
  logic [7:0]    needle [NEEDLE_MAX];
  logic          pg_q, pg_d;
  logic          found_q, found_d;
  logic [LW-1:0] len;
  logic [NEEDLE_MAX:0] tail_vec;
  logic          tail;
  logic          mism;
  logic [CW:0]   cnt_inc;
  logic [CW:0]   cnt_cap;
  logic          long_enough;

  assign len = (cfg_i.needle_length > 5'(NEEDLE_MAX)) ? LW'(NEEDLE_MAX)
                                                      : cfg_i.needle_length[LW-1:0];

  always_comb begin
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      needle[i] = cfg_i.needle[8*i +: 8];
    end
  end

  // Window as it stands after this item: shifted only when a byte arrives
  always_comb begin
    cw[0] = item_i.is_empty ? win_q[0] : item_i.data_byte;
    for (int j = 1; j < NEEDLE_MAX; j++) begin
      cw[j] = item_i.is_empty ? win_q[j] : win_q[j-1];
    end
  end

  // tail_vec[L]: newest L bytes equal needle bytes 0..L-1 (oldest first)
  always_comb begin
    tail_vec[0] = 1'b1;
    for (int l = 1; l <= NEEDLE_MAX; l++) begin
      tail_vec[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (cw[l-1-i] != needle[i]) tail_vec[l] = 1'b0;
      end
    end
  end
  assign tail = tail_vec[len];

  always_comb begin
    mism = 1'b0;
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      if (cnt_q == CW'(i) && CW'(i) < CW'(len) && item_i.data_byte != needle[i]) mism = 1'b1;
    end
  end

  assign cnt_inc = {1'b0, cnt_q} + (CW+1)'(1);
  assign cnt_cap = (CW+1)'(len) + (CW+1)'(1);

  always_comb begin
    if (item_i.is_empty) begin
      cnt_d = cnt_q;
    end else if (cnt_inc > cnt_cap) begin
      cnt_d = cnt_cap[CW-1:0];
    end else begin
      cnt_d = cnt_inc[CW-1:0];
    end
  end

  assign long_enough = cnt_d >= CW'(len);
  assign pg_d    = pg_q & ~(~item_i.is_empty & mism);
  assign found_d = found_q | (~item_i.is_empty & (len != '0) & long_enough & tail);

  always_comb begin
    unique case (mode_e'(cfg_i.match_mode))
      MODE_ALL:      match_o = 1'b1;
      MODE_EQUALS:   match_o = pg_d & (cnt_d == CW'(len));
      MODE_STARTS:   match_o = pg_d & long_enough;
      MODE_ENDS:     match_o = long_enough & tail;
      MODE_CONTAINS: match_o = (len == '0) | found_d;
      default:       match_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pg_q    <= 1'b1;
      found_q <= 1'b0;
      for (int j = 0; j < NEEDLE_MAX; j++) win_q[j] <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        cnt_q   <= '0;
        pg_q    <= 1'b1;
        found_q <= 1'b0;
        for (int j = 0; j < NEEDLE_MAX; j++) win_q[j] <= '0;
      end else begin
        cnt_q   <= cnt_d;
        pg_q    <= pg_d;
        found_q <= found_d;
        for (int j = 0; j < NEEDLE_MAX; j++) win_q[j] <= cw[j];
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_byte |=> cnt_q == '0 && pg_q && !found_q)
    else $error("string state not cleared after last beat");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NEEDLE_MAX + 1))
    else $error("byte count beyond saturation");

  // an empty beat inside a string leaves the per-string state alone
  a_empty_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.is_empty && !item_i.last_byte
    |=> $stable(cnt_q) && $stable(pg_q) && $stable(found_q))
    else $error("empty beat changed string state");

endmodule

// ----- hdl/constant_pattern_string_filter_top.sv -----
// Constant-pattern string filter: stream in/out, APB config, input and result registers.
// Depends on cpsf_pkg and cpsf_core.
//
// Usage:
//   s_axis carries one string byte per beat: tdata = data_byte, tuser = is_empty,
//   tlast = end of the string. An empty string is a single beat with tuser and
//   tlast high. One m_axis beat per string, tdata[0] = match, after its tlast beat.
//   Config over APB (64-bit data): 0x00 match_mode, 0x08 needle_length,
//   0x10 needle bytes 0..7, 0x18 needle bytes 8..15. Write only while idle.
//   Throughput: one beat per cycle while s_axis_tready is high. Path: an accepted
//   tlast beat lands in the input register; once it advances, the window compare
//   lands in the result register, which drives m_axis.
//   Stall: while a result waits on m_axis, non-last beats keep flowing; a
//   further tlast beat parks in the input register and s_axis_tready drops
//   until the waiting result is taken.
//   Reset: config, valid flags and per-string state clear; needle empty, mode match-all.
module constant_pattern_string_filter_top import cpsf_pkg::*; #(
  parameter int unsigned NEEDLE_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] is_empty
  input  logic        s_axis_tlast,
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] match, [7:1] zero
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t  cfg_q;
  item_t s1_q;
  logic  s1_valid_q;
  logic  adv;
  logic  out_valid_q;
  logic  out_match_q;
  logic  match;
  logic  cfg_wr;
  reg_e  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[4:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:   cfg_q.match_mode    <= pwdata[2:0];
        REG_LENGTH: cfg_q.needle_length <= pwdata[4:0];
        REG_LOW:    cfg_q.needle[63:0]  <= pwdata;
        REG_HIGH:   cfg_q.needle[127:64] <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = {61'd0, cfg_q.match_mode};
      REG_LENGTH: prdata = {59'd0, cfg_q.needle_length};
      REG_LOW:    prdata = cfg_q.needle[63:0];
      REG_HIGH:   prdata = cfg_q.needle[127:64];
      default:    prdata = '0;
    endcase
  end

  // A last beat may only leave the input register when the result slot is free
  assign adv = s1_valid_q & (~s1_q.last_byte | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_q.data_byte <= s_axis_tdata;
      s1_q.is_empty  <= s_axis_tuser;
      s1_q.last_byte <= s_axis_tlast;
    end
  end

  cpsf_core #(
    .NEEDLE_MAX(NEEDLE_MAX)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .step_i (adv),
    .item_i (s1_q),
    .match_o(match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_q.last_byte) begin
      out_match_q <= match;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_match_q};

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_q.last_byte |=> out_valid_q)
    else $error("last beat processed without a result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && s1_q.last_byte && out_valid_q && !m_axis_tready)
    else $error("input stalled without a pending result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !(adv && s1_q.last_byte))
    else $error("waiting result overwritten");

endmodule

// ----- tb/pattern_match_checker.sv -----
// Match checker for the constant-pattern string filter: tracks APB register writes,
// predicts one match bit per finished string from the accepted s_axis beats and
// compares each m_axis beat with it. Depends on cpsf_pkg.
`timescale 1ns / 100ps

module pattern_match_checker import cpsf_pkg::*; #(
  parameter int unsigned NEEDLE_MAX = NeedleBytesMax
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] is_empty
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [0] match, [7:1] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          mismatch_count_o,
  output int          pending_o
);

  logic [2:0]   mode_q;
  logic [4:0]   length_q;
  logic [127:0] needle_q;

  int unsigned  seen_q;           // saturates at effective length + 1
  logic [7:0]   recent_q [16];    // entry 0 is the newest byte
  logic         prefix_ok_q;
  logic         found_q;

  logic         match_due [$];
  logic [7:0]   want;

  function automatic logic [7:0] needle_byte(int unsigned pos);
    return needle_q[8*(pos % 16) +: 8];
  endfunction

  // newest len bytes equal the needle
  function automatic logic tail_hits(int unsigned len);
    for (int unsigned i = 0; i < len && i < 16; i++) begin
      if (recent_q[len-1-i] != needle_byte(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_string();
    seen_q = 0;
    foreach (recent_q[i]) recent_q[i] = '0;
    prefix_ok_q = 1'b1;
    found_q = 1'b0;
  endtask

  task automatic absorb_beat(logic [7:0] b, logic empty, logic last);
    int unsigned len;
    logic hit;
    len = (length_q > NEEDLE_MAX) ? NEEDLE_MAX : length_q;
    if (!empty) begin
      if (seen_q < len && b != needle_byte(seen_q)) prefix_ok_q = 1'b0;
      for (int i = 15; i > 0; i--) recent_q[i] = recent_q[i-1];
      recent_q[0] = b;
      seen_q = (seen_q + 1 > len + 1) ? len + 1 : seen_q + 1;
      if (len > 0 && seen_q >= len && tail_hits(len)) found_q = 1'b1;
    end
    if (last) begin
      case (mode_q)
        MODE_ALL:      hit = 1'b1;
        MODE_EQUALS:   hit = prefix_ok_q && seen_q == len;
        MODE_STARTS:   hit = prefix_ok_q && seen_q >= len;
        MODE_ENDS:     hit = seen_q >= len && tail_hits(len);
        MODE_CONTAINS: hit = len == 0 || found_q;
        default:       hit = 1'b0;
      endcase
      match_due.push_back(hit);
      clear_string();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_ALL;
      length_q = '0;
      needle_q = '0;
      clear_string();
      match_due.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[4:3]))
          REG_MODE:   mode_q = pwdata[2:0];
          REG_LENGTH: length_q = pwdata[4:0];
          REG_LOW:    needle_q[63:0] = pwdata;
          REG_HIGH:   needle_q[127:64] = pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (match_due.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result beat with none expected, expected none actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = {7'd0, match_due.pop_front()};
          if (m_axis_tdata !== want) begin
            mismatch_count_o++;
            $display("%0t: match mismatch, expected %h actual %h",
                     $time, want, m_axis_tdata);
          end
        end
      end
      pending_o = match_due.size();
    end
  end

endmodule

// ----- tb/constant_pattern_string_filter_top_tb.sv -----
// Testbench top for the constant-pattern string filter: reset, APB setup, directed
// and random string streams under varying idle/stall, final verdict.
// Depends on cpsf_pkg, constant_pattern_string_filter_top and pattern_match_checker.
`timescale 1ns / 100ps

module constant_pattern_string_filter_top_tb import cpsf_pkg::*;;

  localparam logic [2:0] ModeUndefined = 3'd7;
  localparam logic [127:0] EdgeNeedle = {112'd0, 16'hFF00};  // bytes 00, FF

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

  constant_pattern_string_filter_top #(.NEEDLE_MAX(NeedleBytesMax)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pattern_match_checker #(.NEEDLE_MAX(NeedleBytesMax)) u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count_o(mismatches), .pending_o(pending)
  );

  // called at a rising edge; returns at the edge where the beat was taken
  task automatic send_beat(logic [7:0] b, logic empty, logic last);
    logic ok;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= empty;
    s_axis_tlast <= last;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    if (!empty || last) items_sent++;
  endtask

  // drain: no beat offered, all matches back, pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves psel high so back-to-back writes need no drop
  task automatic write_reg(reg_e idx, logic [63:0] value);
    logic ok;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = pready;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic set_filter(logic [2:0] mode, logic [4:0] nlen, logic [127:0] needle);
    settle();
    write_reg(REG_MODE, {61'd0, mode});
    write_reg(REG_LENGTH, {59'd0, nlen});
    write_reg(REG_LOW, needle[63:0]);
    write_reg(REG_HIGH, needle[127:64]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // strings mostly over a two-byte alphabet shared with the needle, often with the
  // needle planted at the start, the end or somewhere inside
  task automatic random_round();
    logic [7:0]   alpha [2];
    logic [7:0]   text [$];
    logic [127:0] needle;
    logic [2:0]   mode;
    logic [4:0]   nlen;
    logic         close_empty;
    int           eff, slen, at, pick;
    alpha[0] = 8'($urandom);
    alpha[1] = 8'($urandom);
    pick = $urandom_range(0, 11);
    mode = (pick < 8) ? 3'(pick) : 3'(pick - 7);
    pick = $urandom_range(0, 9);
    case (pick)
      0:       nlen = 5'd0;
      1:       nlen = 5'd16;
      2:       nlen = 5'($urandom_range(17, 31));
      3:       nlen = 5'($urandom_range(9, 15));
      default: nlen = 5'($urandom_range(1, 8));
    endcase
    for (int i = 0; i < 16; i++) begin
      needle[8*i +: 8] = ($urandom_range(0, 6) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 1)];
    end
    eff = (nlen > 16) ? 16 : nlen;
    set_filter(mode, nlen, needle);
    repeat ($urandom_range(3, 10)) begin
      pick = $urandom_range(0, 19);
      slen = (pick == 0) ? 0 : (pick < 5) ? eff : $urandom_range(1, 20);
      text.delete();
      repeat (slen) begin
        text.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 1)]);
      end
      if (eff > 0 && slen >= eff && $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 2);
        at = (pick == 0) ? 0 : (pick == 1) ? slen - eff : $urandom_range(0, slen - eff);
        for (int i = 0; i < eff; i++) text[at+i] = needle[8*i +: 8];
      end
      close_empty = ($urandom_range(0, 9) == 0);
      if (slen == 0) begin
        send_beat(8'($urandom), 1'b1, 1'b1);
      end else begin
        for (int i = 0; i < slen; i++) begin
          // stray empty beat inside a string, ignored by the block
          if ($urandom_range(0, 24) == 0) send_beat(8'($urandom), 1'b1, 1'b0);
          send_beat(text[i], 1'b0, (i == slen - 1) && !close_empty);
        end
        if (close_empty) send_beat(8'($urandom), 1'b1, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty needle: only the empty string is equal
    set_filter(MODE_EQUALS, 5'd0, '0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b1);
    set_filter(MODE_STARTS, 5'd2, EdgeNeedle);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h12, 1'b0, 1'b1);
    set_filter(MODE_ENDS, 5'd2, EdgeNeedle);
    send_beat(8'h12, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    // stray empty beat mid-string, then an empty last beat closes it
    set_filter(MODE_CONTAINS, 5'd2, EdgeNeedle);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    set_filter(MODE_ALL, 5'd16, '1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
    set_filter(ModeUndefined, 5'd0, '0);
    send_beat(8'hFF, 1'b0, 1'b1);
    // length above the maximum is clipped to 16
    set_filter(MODE_CONTAINS, 5'd31, '1);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      while (items_sent < 20 + (ph + 1) * 283) random_round();
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/cpsf_pkg.sv
hdl/cpsf_core.sv
hdl/constant_pattern_string_filter_top.sv
tb/pattern_match_checker.sv
tb/constant_pattern_string_filter_top_tb.sv
